// ===== design/wrc_pkg.sv =====
package wrc_pkg;

    // Sizes
    localparam int MAX_DIMS    = 64;
    localparam int IDX_W       = 6;
    localparam int VL_W        = 7;
    localparam int COV_DEPTH   = MAX_DIMS * MAX_DIMS;
    localparam int COV_AW      = 2 * IDX_W;
    localparam int QUEUE_DEPTH = 2;

    // Shared multiplier operand widths (3 x 2 limbs of 32 bits)
    localparam int MUL_A_W = 96;
    localparam int MUL_B_W = 64;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Action codes
    localparam logic [1:0] ACT_ACCUM     = 2'd0;
    localparam logic [1:0] ACT_READ_MEAN = 2'd1;
    localparam logic [1:0] ACT_READ_COV  = 2'd2;
    localparam logic [1:0] ACT_CLEAR     = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX   = 2'd1;
    localparam logic [1:0] ST_ZERO_WEIGHT = 2'd2;
    localparam logic [1:0] ST_ORDER       = 2'd3;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        K_ACCUM     = 3'd0,
        K_READ_MEAN = 3'd1,
        K_READ_COV  = 3'd2,
        K_CLEAR     = 3'd3,
        K_BAD_INDEX = 3'd4
    } kind_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] sample_value;
        logic [31:0]        weight;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   col_index;
        logic               last_element;
    } cmd_t;

    typedef struct packed {
        logic signed [63:0] read_value;
        logic [1:0]         status;
        logic               update_done;
    } result_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] sample_value;
        logic [31:0]        weight;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   col_index;
        logic               last_element;
    } qcmd_t;

endpackage

// ===== design/weighted_running_covariance.sv =====
// Channel   Ports                          Transaction
// --------  -----------------------------  ----------------------------------
// command   start, busy, cmd               start && !busy at a rising edge
// result    done, result                   done high for one cycle, no stall
// config    cfg_we, cfg_data               cfg_we at a rising edge
//
// At the head of the queue, an index error is answered from the idle state,
// an order or zero-weight error from the accumulate check, and a read from
// the read-out state. An accumulate element runs the check, difference and
// mean step, plus the ratio divider on element 0; the last element also
// walks N(N+1)/2 covariance entries through the shared multiplier, plus a
// multiply per row. After reset, and for a clear, the covariance memory is
// swept with busy high. A two-entry queue decouples command intake; busy
// rises when it is full. Results cannot be stalled.
module weighted_running_covariance (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  wrc_pkg::cmd_t            cmd,
    input  logic                     cfg_we,
    input  logic [wrc_pkg::VL_W-1:0] cfg_data,
    output logic                     done,
    output wrc_pkg::result_t         result
);

    logic                     push;
    logic                     q_full;
    logic                     q_valid;
    logic                     q_pop;
    logic                     clearing;
    wrc_pkg::qcmd_t           push_cmd;
    wrc_pkg::qcmd_t           head_cmd;
    logic [wrc_pkg::VL_W-1:0] vector_length;

    wrc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .clearing      (clearing),
        .push          (push),
        .qcmd          (push_cmd),
        .vector_length (vector_length)
    );

    wrc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .pop   (q_pop),
        .dout  (head_cmd),
        .valid (q_valid),
        .full  (q_full)
    );

    wrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .cfg_we        (cfg_we),
        .vector_length (vector_length),
        .clearing      (clearing),
        .done          (done),
        .result        (result)
    );

endmodule

// ===== design/wrc_ram.sv =====
module wrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/wrc_mul.sv =====
module wrc_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wrc_pkg::MUL_A_W-1:0] a,
    input  logic [wrc_pkg::MUL_B_W-1:0] b,
    output logic                        done,
    output logic [wrc_pkg::MUL_P_W-1:0] prod
);

    logic [wrc_pkg::MUL_A_W-1:0] a_reg;
    logic [wrc_pkg::MUL_B_W-1:0] b_reg;
    logic [2:0]                  cnt_reg;
    logic                        run_reg;
    logic [63:0]                 pp_reg;
    logic [1:0]                  sh_reg;
    logic                        ppv_reg;
    logic                        pplast_reg;
    logic [wrc_pkg::MUL_P_W-1:0] acc_reg;
    logic                        done_reg;

    logic [31:0]                 a_limb;
    logic [31:0]                 b_limb;
    logic [wrc_pkg::MUL_P_W-1:0] pp_shifted;

    // Limb select: cnt[2:1] picks the a limb, cnt[0] the b limb
    always_comb
    begin
        case (cnt_reg[2:1])
            2'd0:    a_limb = a_reg[31:0];
            2'd1:    a_limb = a_reg[63:32];
            2'd2:    a_limb = a_reg[95:64];
            default: a_limb = '0;
        endcase
        b_limb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    end

    // Partial product placed at its limb offset
    always_comb
    begin
        pp_shifted = {{(wrc_pkg::MUL_P_W-64){1'b0}}, pp_reg} << {sh_reg, 5'd0};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            run_reg    <= 1'b0;
            ppv_reg    <= 1'b0;
            pplast_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ppv_reg    <= run_reg;
            pplast_reg <= run_reg && (cnt_reg == 3'd5);
            done_reg   <= ppv_reg && pplast_reg;
            if (start)
            begin
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: one 32x32 product per cycle, registered before the add
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (ppv_reg)
        begin
            acc_reg <= acc_reg + pp_shifted;
        end
        pp_reg <= a_limb * b_limb;
        sh_reg <= cnt_reg[2:1] + {1'b0, cnt_reg[0]};
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== design/wrc_fifo.sv =====
module wrc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wrc_pkg::qcmd_t din,
    input  logic           pop,
    output wrc_pkg::qcmd_t dout,
    output logic           valid,
    output logic           full
);

    localparam int PTR_W = $clog2(wrc_pkg::QUEUE_DEPTH);

    wrc_pkg::qcmd_t   mem_reg [wrc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign valid = (count_reg != '0);
    assign full  = (count_reg == (PTR_W+1)'(wrc_pkg::QUEUE_DEPTH));

endmodule

// ===== design/wrc_front.sv =====
module wrc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  wrc_pkg::cmd_t             cmd,
    input  logic                      cfg_we,
    input  logic [wrc_pkg::VL_W-1:0]  cfg_data,
    input  logic                      q_full,
    input  logic                      clearing,
    output logic                      push,
    output wrc_pkg::qcmd_t            qcmd,
    output logic [wrc_pkg::VL_W-1:0]  vector_length
);

    logic [wrc_pkg::VL_W-1:0] vl_reg;
    logic [wrc_pkg::VL_W-1:0] vl_next;
    logic [wrc_pkg::VL_W-1:0] row_ext;
    logic [wrc_pkg::VL_W-1:0] col_ext;
    wrc_pkg::kind_t           kind;

    // Vector length register, clamped to 1..MAX_DIMS
    always_comb
    begin
        if (cfg_data == '0)
        begin
            vl_next = wrc_pkg::VL_W'(1);
        end
        else if (cfg_data > wrc_pkg::VL_W'(wrc_pkg::MAX_DIMS))
        begin
            vl_next = wrc_pkg::VL_W'(wrc_pkg::MAX_DIMS);
        end
        else
        begin
            vl_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vl_reg <= wrc_pkg::VL_W'(1);
        end
        else if (cfg_we)
        begin
            vl_reg <= vl_next;
        end
    end

    // Classify the incoming transaction and check its indexes
    always_comb
    begin
        row_ext = {1'b0, cmd.row_index};
        col_ext = {1'b0, cmd.col_index};
        case (cmd.action)
            wrc_pkg::ACT_ACCUM:
                kind = (row_ext < vl_reg) ? wrc_pkg::K_ACCUM : wrc_pkg::K_BAD_INDEX;
            wrc_pkg::ACT_READ_MEAN:
                kind = (row_ext < vl_reg) ? wrc_pkg::K_READ_MEAN : wrc_pkg::K_BAD_INDEX;
            wrc_pkg::ACT_READ_COV:
                kind = (row_ext <= col_ext && col_ext < vl_reg) ?
                       wrc_pkg::K_READ_COV : wrc_pkg::K_BAD_INDEX;
            default:
                kind = wrc_pkg::K_CLEAR;
        endcase
    end

    assign busy              = q_full || clearing;
    assign push              = start && !busy;
    assign qcmd.kind         = kind;
    assign qcmd.sample_value = cmd.sample_value;
    assign qcmd.weight       = cmd.weight;
    assign qcmd.row_index    = cmd.row_index;
    assign qcmd.col_index    = cmd.col_index;
    assign qcmd.last_element = cmd.last_element;
    assign vector_length     = vl_reg;

endmodule

// ===== design/wrc_back.sv =====
module wrc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  wrc_pkg::qcmd_t            q_cmd,
    output logic                      q_pop,
    input  logic                      cfg_we,
    input  logic [wrc_pkg::VL_W-1:0]  vector_length,
    output logic                      clearing,
    output logic                      done,
    output wrc_pkg::result_t          result
);

    localparam int IW = wrc_pkg::IDX_W;
    localparam int AW = wrc_pkg::COV_AW;

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_ACC   = 15'b000000000000100,
        S_DIV   = 15'b000000000001000,
        S_DIFF  = 15'b000000000010000,
        S_MSTEP = 15'b000000000100000,
        S_FMUL  = 15'b000000001000000,
        S_JRD   = 15'b000000010000000,
        S_JLD   = 15'b000000100000000,
        S_JMUL  = 15'b000001000000000,
        S_KRD   = 15'b000010000000000,
        S_KLD   = 15'b000100000000000,
        S_KMUL  = 15'b001000000000000,
        S_RD    = 15'b010000000000000,
        S_RDOUT = 15'b100000000000000
    } state_t;

    function automatic logic [47:0] mag48(input logic [47:0] v);
        return v[47] ? (48'd0 - v) : v;
    endfunction

    state_t           state_reg, state_next;
    wrc_pkg::qcmd_t   cur_reg, cur_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             clr_emit_reg, clr_emit_next;
    logic [47:0]      weight_total_reg, weight_total_next;
    logic [47:0]      total_tmp_reg, total_tmp_next;
    logic [31:0]      ratio_reg, ratio_next;
    logic [31:0]      cw_reg, cw_next;
    logic [IW-1:0]    next_el_reg, next_el_next;
    logic [62:0]      num_reg, num_next;
    logic [47:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic [5:0]       div_cnt_reg, div_cnt_next;
    logic [47:0]      mean_hold_reg, mean_hold_next;
    logic [31:0]      f_reg, f_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [IW-1:0]    k_reg, k_next;
    logic [47:0]      dj_reg, dj_next;
    logic [47:0]      dk_reg, dk_next;
    logic [79:0]      g_reg, g_next;
    logic [63:0]      cov_old_reg, cov_old_next;
    logic             done_reg, done_next;
    wrc_pkg::result_t result_reg, result_next;

    // Memory ports
    logic             mean_we, diff_we, cov_we;
    logic [IW-1:0]    mean_waddr, diff_raddr;
    logic [47:0]      mean_wdata, mean_rd, diff_rd;
    logic [AW-1:0]    cov_waddr, cov_raddr;
    logic [63:0]      cov_wdata, cov_rd;

    // Multiplier port
    logic                        mul_start, mul_done;
    logic [wrc_pkg::MUL_A_W-1:0] mul_a;
    logic [wrc_pkg::MUL_B_W-1:0] mul_b;
    logic [wrc_pkg::MUL_P_W-1:0] mul_p;

    // Datapath temporaries
    logic [48:0]      total49;
    logic [47:0]      total48;
    logic [48:0]      trial;
    logic             qbit;
    logic [47:0]      x48;
    logic [48:0]      diff49;
    logic [47:0]      d_comb;
    logic [47:0]      step;
    logic [48:0]      mean49;
    logic [47:0]      mean_new;
    logic [32:0]      one_minus_r;
    logic [62:0]      term;
    logic [64:0]      sum65;
    logic [63:0]      cov_new;
    logic             order_bad;
    logic [IW-1:0]    row;

    wrc_ram #(.WIDTH(48), .DEPTH(wrc_pkg::MAX_DIMS)) u_mean_ram (
        .clk   (clk),
        .we    (mean_we),
        .waddr (mean_waddr),
        .wdata (mean_wdata),
        .raddr (cur_reg.row_index),
        .rdata (mean_rd)
    );

    wrc_ram #(.WIDTH(48), .DEPTH(wrc_pkg::MAX_DIMS)) u_diff_ram (
        .clk   (clk),
        .we    (diff_we),
        .waddr (cur_reg.row_index),
        .wdata (d_comb),
        .raddr (diff_raddr),
        .rdata (diff_rd)
    );

    wrc_ram #(.WIDTH(64), .DEPTH(wrc_pkg::COV_DEPTH)) u_cov_ram (
        .clk   (clk),
        .we    (cov_we),
        .waddr (cov_waddr),
        .wdata (cov_wdata),
        .raddr (cov_raddr),
        .rdata (cov_rd)
    );

    wrc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    // Read addresses follow the state
    assign diff_raddr = (state_reg == S_KRD) ? k_reg : j_reg;
    assign cov_raddr  = (state_reg == S_RD) ? {cur_reg.row_index, cur_reg.col_index}
                                            : {j_reg, k_reg};

    // Arithmetic shared by the states
    always_comb
    begin
        row     = cur_reg.row_index;
        total49 = {1'b0, weight_total_reg} + {17'd0, cur_reg.weight};
        total48 = total49[48] ? '1 : total49[47:0];
        trial   = {rem_reg, num_reg[62]};
        qbit    = (trial >= {1'b0, total_tmp_reg});
        x48     = {cur_reg.sample_value, 16'd0};
        diff49  = {x48[47], x48} - {mean_rd[47], mean_rd};
        if (diff49[48] != diff49[47])
        begin
            d_comb = diff49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            d_comb = diff49[47:0];
        end
        step   = mul_p[78:31];
        mean49 = dj_reg[47] ? ({mean_hold_reg[47], mean_hold_reg} - {1'b0, step})
                            : ({mean_hold_reg[47], mean_hold_reg} + {1'b0, step});
        if (mean49[48] != mean49[47])
        begin
            mean_new = mean49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            mean_new = mean49[47:0];
        end
        one_minus_r = 33'h080000000 - {1'b0, ratio_reg};
        term = (|mul_p[159:111]) ? '1 : mul_p[110:48];
        sum65 = (dj_reg[47] ^ dk_reg[47]) ?
                ({cov_old_reg[63], cov_old_reg} - {2'b0, term}) :
                ({cov_old_reg[63], cov_old_reg} + {2'b0, term});
        if (sum65[64] != sum65[63])
        begin
            cov_new = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            cov_new = sum65[63:0];
        end
        order_bad = (row != next_el_reg) ||
                    (cur_reg.last_element != (({1'b0, row} + 7'd1) == vector_length));
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        clr_cnt_next      = clr_cnt_reg;
        clr_emit_next     = clr_emit_reg;
        weight_total_next = weight_total_reg;
        total_tmp_next    = total_tmp_reg;
        ratio_next        = ratio_reg;
        cw_next           = cw_reg;
        next_el_next      = next_el_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        div_cnt_next      = div_cnt_reg;
        mean_hold_next    = mean_hold_reg;
        f_next            = f_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        dj_next           = dj_reg;
        dk_next           = dk_reg;
        g_next            = g_reg;
        cov_old_next      = cov_old_reg;
        done_next         = 1'b0;
        result_next       = result_reg;
        q_pop             = 1'b0;
        mean_we           = 1'b0;
        mean_waddr        = row;
        mean_wdata        = mean_new;
        diff_we           = 1'b0;
        cov_we            = 1'b0;
        cov_waddr         = {j_reg, k_reg};
        cov_wdata         = cov_new;
        mul_start         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;

        case (state_reg)
            // Zero every covariance and mean entry, one per cycle
            S_CLEAR:
            begin
                weight_total_next = '0;
                ratio_next        = '0;
                cw_next           = '0;
                next_el_next      = '0;
                cov_we            = 1'b1;
                cov_waddr         = clr_cnt_reg;
                cov_wdata         = '0;
                if (clr_cnt_reg < AW'(wrc_pkg::MAX_DIMS))
                begin
                    mean_we    = 1'b1;
                    mean_waddr = clr_cnt_reg[IW-1:0];
                    mean_wdata = '0;
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(wrc_pkg::COV_DEPTH - 1))
                begin
                    state_next    = S_IDLE;
                    clr_emit_next = 1'b0;
                    if (clr_emit_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '{read_value: '0, status: wrc_pkg::ST_OK,
                                        update_done: 1'b0};
                    end
                end
            end

            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_cmd;
                    case (q_cmd.kind)
                        wrc_pkg::K_ACCUM:     state_next = S_ACC;
                        wrc_pkg::K_READ_MEAN: state_next = S_RD;
                        wrc_pkg::K_READ_COV:  state_next = S_RD;
                        wrc_pkg::K_CLEAR:
                        begin
                            state_next    = S_CLEAR;
                            clr_emit_next = 1'b1;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{read_value: '0,
                                            status: wrc_pkg::ST_BAD_INDEX,
                                            update_done: 1'b0};
                        end
                    endcase
                end
            end

            // Order and weight checks; element 0 also loads the ratio divider
            S_ACC:
            begin
                if (order_bad)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{read_value: '0, status: wrc_pkg::ST_ORDER,
                                    update_done: 1'b0};
                end
                else if (row == '0)
                begin
                    if (total48 == '0)
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        result_next = '{read_value: '0, status: wrc_pkg::ST_ZERO_WEIGHT,
                                        update_done: 1'b0};
                    end
                    else
                    begin
                        total_tmp_next = total48;
                        cw_next        = cur_reg.weight;
                        num_next       = {cur_reg.weight, 31'd0};
                        rem_next       = '0;
                        quo_next       = '0;
                        div_cnt_next   = '0;
                        state_next     = S_DIV;
                    end
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end

            // r = weight * 2^31 / total, one quotient bit per cycle
            S_DIV:
            begin
                rem_next     = qbit ? 48'(trial - {1'b0, total_tmp_reg}) : trial[47:0];
                num_next     = {num_reg[61:0], 1'b0};
                quo_next     = {quo_reg[30:0], qbit};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd62)
                begin
                    ratio_next        = {quo_reg[30:0], qbit};
                    weight_total_next = total_tmp_reg;
                    state_next        = S_DIFF;
                end
            end

            // Difference from the old mean, then |d| * r
            S_DIFF:
            begin
                dj_next        = d_comb;
                mean_hold_next = mean_rd;
                diff_we        = 1'b1;
                mul_start      = 1'b1;
                mul_a          = {48'd0, mag48(d_comb)};
                mul_b          = {32'd0, ratio_reg};
                state_next     = S_MSTEP;
            end

            // Move the mean; on the last element start (1 - r) * weight
            S_MSTEP:
            begin
                if (mul_done)
                begin
                    mean_we = 1'b1;
                    if (cur_reg.last_element)
                    begin
                        next_el_next = '0;
                        mul_start    = 1'b1;
                        mul_a        = {64'd0, one_minus_r[31:0]};
                        mul_b        = {32'd0, cw_reg};
                        state_next   = S_FMUL;
                    end
                    else
                    begin
                        next_el_next = row + 1'b1;
                        state_next   = S_IDLE;
                        done_next    = 1'b1;
                        result_next  = '{read_value: '0, status: wrc_pkg::ST_OK,
                                         update_done: 1'b0};
                    end
                end
            end

            S_FMUL:
            begin
                if (mul_done)
                begin
                    f_next     = mul_p[62:31];
                    j_next     = '0;
                    state_next = S_JRD;
                end
            end

            S_JRD:
            begin
                state_next = S_JLD;
            end

            // g = |d_j| * f for the whole row
            S_JLD:
            begin
                dj_next    = diff_rd;
                mul_start  = 1'b1;
                mul_a      = {48'd0, mag48(diff_rd)};
                mul_b      = {32'd0, f_reg};
                state_next = S_JMUL;
            end

            S_JMUL:
            begin
                if (mul_done)
                begin
                    g_next     = mul_p[79:0];
                    k_next     = j_reg;
                    state_next = S_KRD;
                end
            end

            S_KRD:
            begin
                state_next = S_KLD;
            end

            S_KLD:
            begin
                dk_next      = diff_rd;
                cov_old_next = cov_rd;
                mul_start    = 1'b1;
                mul_a        = {16'd0, g_reg};
                mul_b        = {16'd0, mag48(diff_rd)};
                state_next   = S_KMUL;
            end

            // Accumulate one upper-triangle entry
            S_KMUL:
            begin
                if (mul_done)
                begin
                    cov_we = 1'b1;
                    if ({1'b0, k_reg} == vector_length - 7'd1)
                    begin
                        if ({1'b0, j_reg} == vector_length - 7'd1)
                        begin
                            state_next  = S_IDLE;
                            done_next   = 1'b1;
                            result_next = '{read_value: '0, status: wrc_pkg::ST_OK,
                                            update_done: 1'b1};
                        end
                        else
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = S_JRD;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_KRD;
                    end
                end
            end

            S_RD:
            begin
                state_next = S_RDOUT;
            end

            S_RDOUT:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (cur_reg.kind == wrc_pkg::K_READ_MEAN)
                begin
                    result_next = '{read_value: {{16{mean_rd[47]}}, mean_rd},
                                    status: wrc_pkg::ST_OK, update_done: 1'b0};
                end
                else
                begin
                    result_next = '{read_value: cov_rd, status: wrc_pkg::ST_OK,
                                    update_done: 1'b0};
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A length write abandons the observation in progress
        if (cfg_we)
        begin
            next_el_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            clr_emit_reg     <= 1'b0;
            weight_total_reg <= '0;
            ratio_reg        <= '0;
            cw_reg           <= '0;
            next_el_reg      <= '0;
            div_cnt_reg      <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            clr_emit_reg     <= clr_emit_next;
            weight_total_reg <= weight_total_next;
            ratio_reg        <= ratio_next;
            cw_reg           <= cw_next;
            next_el_reg      <= next_el_next;
            div_cnt_reg      <= div_cnt_next;
            done_reg         <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        total_tmp_reg <= total_tmp_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        mean_hold_reg <= mean_hold_next;
        f_reg         <= f_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        dj_reg        <= dj_next;
        dk_reg        <= dk_next;
        g_reg         <= g_next;
        cov_old_reg   <= cov_old_next;
        result_reg    <= result_next;
    end

    assign clearing = (state_reg == S_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.update_done |-> result_reg.status == wrc_pkg::ST_OK)
        else $error("update flagged with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.status != wrc_pkg::ST_OK |-> result_reg.read_value == '0)
        else $error("error result carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, next_el_reg} < vector_length)
        else $error("expected element beyond vector length");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE && q_valid)
        else $error("queue popped outside idle");

endmodule
